### src/qdec_pkg.sv
package qdec_pkg;

   // Widths fixed by the register map and the result fields.
   localparam int CFG_WIDTH       = 24;
   localparam int RATE_WIDTH      = 24;
   localparam int SPEED_WIDTH     = 25;
   localparam int POS_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int DIV_COUNT_WIDTH = $clog2(RATE_WIDTH);

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STALE_LIMIT = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE_SCALE  = CSR_INDEX_WIDTH'(1);

   // Register reset values.
   localparam logic [CFG_WIDTH-1:0] STALE_LIMIT_RESET = CFG_WIDTH'(10000);
   localparam logic [CFG_WIDTH-1:0] RATE_SCALE_RESET  = CFG_WIDTH'(1000000);

   // Decoded transition between two samples of the encoder lines.
   typedef struct packed {
      logic valid_step;
      logic reverse;
      logic a_edge;
      logic illegal;
   } step_type;

endpackage

### src/qdec_if.sv
interface qdec_req_if;
   import qdec_pkg::*;

   logic valid;
   logic ready;
   logic a_level;
   logic b_level;

   modport source (output valid, output a_level, output b_level, input ready);
   modport sink   (input valid, input a_level, input b_level, output ready);
endinterface

interface qdec_rsp_if;
   import qdec_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          direction;
   logic signed [POS_WIDTH-1:0]   position;
   logic signed [SPEED_WIDTH-1:0] speed;
   logic                          illegal_step;

   modport source (output valid, output direction, output position, output speed,
                   output illegal_step, input ready);
   modport sink   (input valid, input direction, input position, input speed,
                   input illegal_step, output ready);
endinterface

### src/qdec_gray.sv
module qdec_gray (
   input  logic               prev_a,
   input  logic               prev_b,
   input  logic               cur_a,
   input  logic               cur_b,
   output qdec_pkg::step_type step
);
   import qdec_pkg::*;

   // Position along the forward sequence 00, 01, 11, 10.
   function automatic logic [1:0] gray_index(input logic a, input logic b);
      return {a, a ^ b};
   endfunction

   logic       da;
   logic       db;
   logic [1:0] delta;

   assign da    = cur_a ^ prev_a;
   assign db    = cur_b ^ prev_b;
   assign delta = gray_index(cur_a, cur_b) - gray_index(prev_a, prev_b);

   assign step.valid_step = da ^ db;
   assign step.reverse    = (delta != 2'd1);
   assign step.a_edge     = (da ^ db) & da;
   assign step.illegal    = da & db;

endmodule

### src/qdec_divider.sv
module qdec_divider #(
   parameter int TIME_WIDTH = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [qdec_pkg::RATE_WIDTH-1:0]  dividend,
   input  logic [TIME_WIDTH-1:0]            divisor,
   output logic                             done,
   output logic [qdec_pkg::RATE_WIDTH-1:0]  quotient
);
   import qdec_pkg::*;

   // Restoring division, one quotient bit per cycle.
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [TIME_WIDTH-1:0]      rem_ff, rem_in;
   logic [RATE_WIDTH-1:0]      quo_ff, quo_in;
   logic [TIME_WIDTH-1:0]      divisor_ff, divisor_in;
   logic [TIME_WIDTH:0]        trial;
   logic [TIME_WIDTH:0]        diff;
   logic                       fits;

   assign trial = {rem_ff, quo_ff[RATE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = DIV_COUNT_WIDTH'(RATE_WIDTH - 1);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
         quo_in   = {quo_ff[RATE_WIDTH-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

### src/quadrature_decoder_with_speed.sv
// Quadrature (x4) encoder decoder with period-based speed.
//
// Each transfer on req_ch is one timebase tick with the sampled A and B
// levels. Each tick gives exactly one transfer on rsp_ch with the held
// direction, the signed position count, the signed edge rate and a flag
// for a tick in which both lines changed. The csr_ port writes the stale
// limit (index 0) and the rate scale (index 1); the user must do so only
// while the block is idle, since the block itself does not enforce it.
// A tick without an A-channel edge is decoded in the cycle it is taken,
// and its result is valid on the next cycle. A tick with an A edge runs
// rate_scale / interval through a restoring divider, one quotient
// bit per cycle; the block waits in DIVIDE, loads the output register
// when the divider signals done, and takes no new tick until then.
// req_ch.ready is low while the divider runs and while a result waits in
// the output register without rsp_ch.ready; a stalled receiver therefore
// holds off the next tick and no result is lost. Synchronous reset clears
// the position, timing and rate state, restores the register defaults and
// empties the output register.
module quadrature_decoder_with_speed #(
   parameter int TIME_WIDTH  = 24,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   qdec_req_if.sink                              req_ch,
   qdec_rsp_if.source                            rsp_ch,
   input  logic                                  csr_write_enable,
   input  logic [qdec_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [qdec_pkg::CFG_WIDTH-1:0]        csr_write_data
);
   import qdec_pkg::*;

   localparam int CMP_WIDTH = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

   typedef enum logic {
      IDLE,
      DIVIDE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [CFG_WIDTH-1:0]   stale_limit_ff, stale_limit_in;
   logic [CFG_WIDTH-1:0]   rate_scale_ff, rate_scale_in;

   // Decoder and timing state.
   logic                   prev_a_ff, prev_a_in;
   logic                   prev_b_ff, prev_b_in;
   logic [COUNT_WIDTH-1:0] step_count_ff, step_count_in;
   logic                   direction_ff, direction_in;
   logic [TIME_WIDTH-1:0]  since_edge_ff, since_edge_in;
   logic [TIME_WIDTH-1:0]  interval_ff, interval_in;
   logic [RATE_WIDTH-1:0]  held_rate_ff, held_rate_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_direction_ff, rsp_direction_in;
   logic signed [POS_WIDTH-1:0]   rsp_position_ff, rsp_position_in;
   logic signed [SPEED_WIDTH-1:0] rsp_speed_ff, rsp_speed_in;
   logic                          rsp_illegal_ff, rsp_illegal_in;

   logic                   accept;
   logic                   div_done;
   logic [RATE_WIDTH-1:0]  div_quotient;
   logic                   div_start;
   logic [TIME_WIDTH-1:0]  elapsed;
   logic                   stale;
   step_type               step;

   // Applies the held direction to an unsigned rate.
   function automatic logic signed [SPEED_WIDTH-1:0] signed_rate(
      input logic reverse, input logic [RATE_WIDTH-1:0] rate);
      logic [SPEED_WIDTH-1:0] ext;
      ext = SPEED_WIDTH'(rate);
      return reverse ? signed'(-ext) : signed'(ext);
   endfunction

   qdec_gray u_gray (
      .prev_a (prev_a_ff),
      .prev_b (prev_b_ff),
      .cur_a  (req_ch.a_level),
      .cur_b  (req_ch.b_level),
      .step   (step)
   );

   qdec_divider #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rate_scale_ff),
      .divisor  (elapsed),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // A new tick is taken only when idle and the output register is free
   // or is being emptied in this cycle.
   assign req_ch.ready = (state_ff == IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign div_start    = accept && step.a_edge;

   // The interval includes this tick, saturating at the counter maximum,
   // so the divisor is never zero.
   assign elapsed = (since_edge_ff == '1) ? since_edge_ff : since_edge_ff + 1'b1;

   // Staleness uses the updated count. Without an A edge the updated count
   // is the elapsed time; an A edge resets it, so such a tick is never
   // stale and does not look at this compare.
   assign stale = CMP_WIDTH'(elapsed) > CMP_WIDTH'(stale_limit_ff);

   always_comb begin
      state_in         = state_ff;
      stale_limit_in   = stale_limit_ff;
      rate_scale_in    = rate_scale_ff;
      prev_a_in        = prev_a_ff;
      prev_b_in        = prev_b_ff;
      step_count_in    = step_count_ff;
      direction_in     = direction_ff;
      since_edge_in    = since_edge_ff;
      interval_in      = interval_ff;
      held_rate_in     = held_rate_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_direction_in = rsp_direction_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_speed_in     = rsp_speed_ff;
      rsp_illegal_in   = rsp_illegal_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STALE_LIMIT: stale_limit_in = csr_write_data;
            CSR_RATE_SCALE:  rate_scale_in  = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               prev_a_in = req_ch.a_level;
               prev_b_in = req_ch.b_level;
               if (step.valid_step) begin
                  direction_in  = step.reverse;
                  step_count_in = step.reverse ? step_count_ff - 1'b1
                                               : step_count_ff + 1'b1;
               end
               if (step.a_edge) begin
                  interval_in   = elapsed;
                  since_edge_in = '0;
               end else begin
                  since_edge_in = elapsed;
               end
               rsp_direction_in = direction_in;
               rsp_position_in  = POS_WIDTH'(signed'(step_count_in));
               rsp_illegal_in   = step.illegal;
               if (step.a_edge) begin
                  state_in = DIVIDE;
               end else begin
                  rsp_speed_in = stale ? '0 : signed_rate(direction_in, held_rate_ff);
                  rsp_valid_in = 1'b1;
               end
            end
         end
         DIVIDE: begin
            // The output register is empty here: it was free when the
            // tick was taken and nothing else loads it.
            if (div_done) begin
               held_rate_in = div_quotient;
               rsp_speed_in = signed_rate(direction_ff, div_quotient);
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         stale_limit_ff <= STALE_LIMIT_RESET;
         rate_scale_ff  <= RATE_SCALE_RESET;
         prev_a_ff      <= 1'b0;
         prev_b_ff      <= 1'b0;
         step_count_ff  <= '0;
         direction_ff   <= 1'b0;
         since_edge_ff  <= '0;
         interval_ff    <= '0;
         held_rate_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stale_limit_ff <= stale_limit_in;
         rate_scale_ff  <= rate_scale_in;
         prev_a_ff      <= prev_a_in;
         prev_b_ff      <= prev_b_in;
         step_count_ff  <= step_count_in;
         direction_ff   <= direction_in;
         since_edge_ff  <= since_edge_in;
         interval_ff    <= interval_in;
         held_rate_ff   <= held_rate_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_direction_ff <= rsp_direction_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_speed_ff     <= rsp_speed_in;
      rsp_illegal_ff   <= rsp_illegal_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.direction    = rsp_direction_ff;
   assign rsp_ch.position     = rsp_position_ff;
   assign rsp_ch.speed        = rsp_speed_ff;
   assign rsp_ch.illegal_step = rsp_illegal_ff;

   // An A edge always leaves a nonzero interval behind for the divider.
   a_interval_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (interval_ff != '0))
      else $error("A edge recorded a zero interval");
   a_edge_divides: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == DIVIDE) && !rsp_valid_ff)
      else $error("A edge did not start a division");
   a_plain_tick_result: assert property (@(posedge clock) disable iff (reset)
      (accept && !step.a_edge) |=> rsp_valid_ff)
      else $error("tick without A edge gave no result");
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == DIVIDE))
      else $error("divider finished outside a division");
   a_divide_empty_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIVIDE) |-> !rsp_valid_ff)
      else $error("result pending while dividing");

endmodule
